// File: src/asp_pkg.sv
// Shared constants, register codes and control structs for the airspeed block.
// No dependencies; imported by every module of the block but asp_checker.
`timescale 1ns / 1ps
`default_nettype none
package asp_pkg;
  localparam int CAL_SAMPLES = 64;
  localparam int AVG_SAMPLES = 16;

  localparam int SMP_W  = 12;
  localparam int SUM_W  = 22;
  localparam int CNT_W  = 11;
  localparam int ZERO_W = 12;
  localparam int DVD_W  = 61;
  localparam int DVS_W  = 51;
  localparam int DCNT_W = 6;
  localparam int RAD_W  = 32;
  localparam int ROOT_W = 16;

  localparam logic [CNT_W-1:0] CAL_TARGET = CNT_W'(CAL_SAMPLES);
  localparam logic [CNT_W-1:0] AVG_TARGET = CNT_W'(AVG_SAMPLES);
  localparam logic [21:0] FULL_SCALE = 22'(4095 * AVG_SAMPLES);
  localparam logic [24:0] MV_SCALE   = 25'd33000000;
  localparam logic [12:0] RHO_K      = 13'd5741;
  localparam logic [16:0] KELVIN_OFS = 17'd27315;

  localparam logic OP_CAL  = 1'b0;
  localparam logic OP_MEAS = 1'b1;

  localparam logic [2:0] REG_SUPPLY = 3'd0;
  localparam logic [2:0] REG_SENS   = 3'd1;
  localparam logic [2:0] REG_ZOFS   = 3'd2;
  localparam logic [2:0] REG_TEMP   = 3'd3;
  localparam logic [2:0] REG_AMB    = 3'd4;

  localparam logic [12:0] SUPPLY_RST = 13'd5000;
  localparam logic [15:0] SENS_RST   = 16'd2000;
  localparam logic [13:0] ZOFS_RST   = 14'd5000;
  localparam logic [14:0] TEMP_RST   = 15'd2000;
  localparam logic [16:0] AMB_RST    = 17'd101325;

  typedef struct packed {
    logic acc;
    logic mul1;
    logic mul2;
    logic sub;
    logic scale;
    logic div_start;
    logic div_sel;
    logic take_p;
    logic sqrt_start;
    logic load_out;
  } asp_cmd_t;

  typedef struct packed {
    logic meas_done;
    logic pos;
    logic p_zero;
    logic div_busy;
    logic sqrt_busy;
  } asp_sts_t;
endpackage
`default_nettype wire

// File: src/asp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on asp_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module asp_div import asp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dvd,
  input  wire logic [DVS_W-1:0] dvs,
  output logic                  busy,
  output logic [DVD_W-1:0]      quot
);
  logic [DVD_W-1:0]  quot_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              ge;

  always_comb begin
    shifted = {rem_r, quot_r[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = shifted >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DCNT_W'(DVD_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dvd;
      rem_r  <= '0;
      dvs_r  <= dvs;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quot_r <= {quot_r[DVD_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;
endmodule
`default_nettype wire

// File: src/asp_sqrt.sv
// Bitwise integer square root, one result bit per cycle.
// Depends on asp_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module asp_sqrt import asp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [RAD_W-1:0] rad,
  output logic                  busy,
  output logic [ROOT_W-1:0]     root
);
  logic [RAD_W-1:0] x_r;
  logic [RAD_W-1:0] r_r;
  logic [RAD_W-1:0] bit_r;
  logic [3:0]       cnt_r;
  logic             busy_r;
  logic [RAD_W:0]   trial;
  logic             take;

  always_comb begin
    trial = {1'b0, r_r} + {1'b0, bit_r};
    take  = {1'b0, x_r} >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'd15;
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= rad;
      r_r   <= '0;
      bit_r <= RAD_W'(1) << (RAD_W - 2);
    end else if (busy_r) begin
      if (take) begin
        x_r <= x_r - trial[RAD_W-1:0];
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = r_r[ROOT_W-1:0];
endmodule
`default_nettype wire

// File: src/asp_dp.sv
// Datapath: sample accumulation, fixed-point pressure and velocity arithmetic.
// Depends on asp_pkg, asp_div and asp_sqrt.
`timescale 1ns / 1ps
`default_nettype none
module asp_dp import asp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire asp_cmd_t         cmd,
  output asp_sts_t              sts,
  input  wire logic             in_opcode,
  input  wire logic [SMP_W-1:0] in_sample,
  input  wire logic [12:0]      supply,
  input  wire logic [15:0]      sens,
  input  wire logic [13:0]      zofs,
  input  wire logic [14:0]      temp,
  input  wire logic [16:0]      amb,
  output logic [15:0]           pressure_out,
  output logic [15:0]           velocity_out,
  output logic                  saturated
);
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              kind_r;
  logic [ZERO_W-1:0] zero_r;
  logic [SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]  cnt_acc;
  logic [CNT_W-1:0]  target;
  logic              run_done;

  logic signed [23:0] d_r;
  logic [26:0]        b1_r;
  logic [28:0]        c1_r;
  logic [28:0]        t1_r;
  logic signed [49:0] a_r;
  logic [48:0]        b_r;
  logic [DVS_W-1:0]   den_r;
  logic signed [50:0] num_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [53:0]        prod2_r;
  logic [15:0]        pout_r;
  logic               psat_r;
  logic               pnz_r;
  logic               qbig_r;
  logic [15:0]        pres_o_r;
  logic [15:0]        vel_o_r;
  logic               sat_o_r;

  logic [23:0]        zsc;
  logic [16:0]        tc_full;
  logic [DVD_W-1:0]   nm;
  logic [24:0]        pcap;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_busy;
  logic [DVD_W-1:0]   quot;
  logic               sqrt_busy;
  logic [ROOT_W-1:0]  root;

  always_comb begin
    if (in_opcode != kind_r) begin
      sum_acc = SUM_W'(in_sample);
      cnt_acc = CNT_W'(1);
    end else begin
      sum_acc = sum_r + SUM_W'(in_sample);
      cnt_acc = cnt_r + CNT_W'(1);
    end
    target   = (in_opcode == OP_MEAS) ? AVG_TARGET : CAL_TARGET;
    run_done = cnt_acc == target;
    zsc      = 24'(zero_r) * 24'(AVG_SAMPLES);
    tc_full  = {{2{temp[14]}}, temp} + KELVIN_OFS;
    nm       = DVD_W'(num_r[46:0]);
    pcap     = (quot > DVD_W'(25'h1000000)) ? 25'h1000000 : quot[24:0];
    div_dvd  = cmd.div_sel ? DVD_W'(prod2_r) : dvd_r;
    div_dvs  = cmd.div_sel ? DVS_W'(amb) : den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      kind_r <= OP_CAL;
      zero_r <= '0;
    end else if (cmd.acc) begin
      kind_r <= in_opcode;
      if (run_done) begin
        cnt_r <= '0;
        if (in_opcode == OP_CAL) begin
          zero_r <= ZERO_W'(sum_acc / CAL_SAMPLES);
          sum_r  <= '0;
        end else begin
          sum_r <= sum_acc;
        end
      end else begin
        sum_r <= sum_acc;
        cnt_r <= cnt_acc;
      end
    end else if (cmd.mul1) begin
      sum_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      d_r  <= $signed({2'b00, sum_r}) - $signed(zsc);
      b1_r <= 27'(zofs) * 27'(supply);
      c1_r <= 29'(sens) * 29'(supply);
      t1_r <= 29'(RHO_K) * 29'(tc_full[15:0]);
    end
    if (cmd.mul2) begin
      a_r   <= d_r * $signed({1'b0, MV_SCALE});
      b_r   <= 49'(b1_r) * 49'(FULL_SCALE);
      den_r <= 51'(c1_r) * 51'(FULL_SCALE);
    end
    if (cmd.sub) begin
      num_r <= a_r - $signed({2'b00, b_r});
    end
    if (cmd.scale) begin
      dvd_r  <= (nm << 13) + (nm << 10) + (nm << 9) + (nm << 8) + (nm << 4);
      pout_r <= '0;
      psat_r <= 1'b0;
      pnz_r  <= 1'b0;
    end
    if (cmd.take_p) begin
      pnz_r   <= quot != '0;
      psat_r  <= quot > DVD_W'(16'hFFFF);
      pout_r  <= (quot > DVD_W'(16'hFFFF)) ? 16'hFFFF : quot[15:0];
      prod2_r <= 54'(pcap) * 54'(t1_r);
    end
    if (cmd.sqrt_start) begin
      qbig_r <= quot[DVD_W-1:RAD_W] != '0;
    end
    if (cmd.load_out) begin
      pres_o_r <= pout_r;
      vel_o_r  <= !pnz_r ? 16'h0 : (qbig_r ? 16'hFFFF : root);
      sat_o_r  <= psat_r | (pnz_r & qbig_r);
    end
  end

  asp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .busy  (div_busy),
    .quot  (quot)
  );

  asp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .rad   (quot[RAD_W-1:0]),
    .busy  (sqrt_busy),
    .root  (root)
  );

  always_comb begin
    sts.meas_done = run_done && (in_opcode == OP_MEAS);
    sts.pos       = !num_r[50] && (num_r != '0) && (den_r != '0);
    sts.p_zero    = quot == '0;
    sts.div_busy  = div_busy;
    sts.sqrt_busy = sqrt_busy;
  end

  assign pressure_out = pres_o_r;
  assign velocity_out = vel_o_r;
  assign saturated    = sat_o_r;
endmodule
`default_nettype wire

// File: src/asp_ctrl.sv
// Controller state machine sequencing accumulation, arithmetic and output.
// Depends on asp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module asp_ctrl import asp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire asp_sts_t sts,
  output asp_cmd_t      cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_SUBT  = 4'd3;
  localparam logic [3:0] S_SCALE = 4'd4;
  localparam logic [3:0] S_DIV1  = 4'd5;
  localparam logic [3:0] S_WAIT1 = 4'd6;
  localparam logic [3:0] S_TAKEP = 4'd7;
  localparam logic [3:0] S_DIV2  = 4'd8;
  localparam logic [3:0] S_WAIT2 = 4'd9;
  localparam logic [3:0] S_ROOT  = 4'd10;
  localparam logic [3:0] S_WAIT3 = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (sts.meas_done) state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_SUBT;
      end
      S_SUBT: begin
        cmd.sub   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = sts.pos ? S_DIV1 : S_FIN;
      end
      S_DIV1: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT1;
      end
      S_WAIT1: begin
        if (!sts.div_busy) state_nxt = S_TAKEP;
      end
      S_TAKEP: begin
        cmd.take_p = 1'b1;
        state_nxt  = sts.p_zero ? S_FIN : S_DIV2;
      end
      S_DIV2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt     = S_WAIT2;
      end
      S_WAIT2: begin
        if (!sts.div_busy) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_WAIT3;
      end
      S_WAIT3: begin
        if (!sts.sqrt_busy) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// File: src/airspeed_from_pressure_samples.sv
// Top level: APB register file, controller and datapath of the airspeed block.
// Depends on asp_pkg, asp_ctrl and asp_dp.
//
// Samples are taken one per cycle while no result is being computed. A
// calibration run of 64 samples stores the zero offset and gives no item; a
// measurement run of 16 samples then goes through the arithmetic (up to two
// passes of the shared restoring divider and a square root) before the result
// item is written to the output register, during which no sample is taken. A
// finished item waits in the output register while the next run is
// accumulated. Registers sit at byte addresses 0..16.
`timescale 1ns / 1ps
`default_nettype none
module airspeed_from_pressure_samples import asp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [11:0] in_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_pressure_out,
  output logic [15:0]      out_velocity_out,
  output logic             out_saturated,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [12:0] supply_r;
  logic [15:0] sens_r;
  logic [13:0] zofs_r;
  logic [14:0] temp_r;
  logic [16:0] amb_r;
  logic        wr_en;
  logic [2:0]  reg_idx;
  asp_cmd_t    cmd;
  asp_sts_t    sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= SUPPLY_RST;
      sens_r   <= SENS_RST;
      zofs_r   <= ZOFS_RST;
      temp_r   <= TEMP_RST;
      amb_r    <= AMB_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SUPPLY: supply_r <= pwdata[12:0];
        REG_SENS:   sens_r   <= pwdata[15:0];
        REG_ZOFS:   zofs_r   <= pwdata[13:0];
        REG_TEMP:   temp_r   <= pwdata[14:0];
        REG_AMB:    amb_r    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SUPPLY: prdata = 32'(supply_r);
      REG_SENS:   prdata = 32'(sens_r);
      REG_ZOFS:   prdata = 32'(zofs_r);
      REG_TEMP:   prdata = 32'(temp_r);
      REG_AMB:    prdata = 32'(amb_r);
      default:    prdata = '0;
    endcase
  end

  asp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  asp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_opcode    (in_opcode),
    .in_sample    (in_sample),
    .supply       (supply_r),
    .sens         (sens_r),
    .zofs         (zofs_r),
    .temp         (temp_r),
    .amb          (amb_r),
    .pressure_out (out_pressure_out),
    .velocity_out (out_velocity_out),
    .saturated    (out_saturated)
  );
endmodule
`default_nettype wire

// File: src/asp_checker.sv
// Port-level checks of the airspeed block, bound to the top level.
// Depends on airspeed_from_pressure_samples ports only.
`timescale 1ns / 1ps
`default_nettype none
module asp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_pressure_out,
  input wire logic [15:0] out_velocity_out,
  input wire logic        out_saturated,
  input wire logic        pready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pressure_out)
      && $stable(out_velocity_out) && $stable(out_saturated))
    else $error("result item changed while stalled");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_pressure_out == 16'hFFFF) || (out_velocity_out == 16'hFFFF))
    else $error("saturated without a clipped field");

  a_zero_p: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pressure_out == 16'h0) |->
      (out_velocity_out == 16'h0) && !out_saturated)
    else $error("speed without pressure");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");
endmodule

bind airspeed_from_pressure_samples asp_checker u_asp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_pressure_out (out_pressure_out),
  .out_velocity_out (out_velocity_out),
  .out_saturated    (out_saturated),
  .pready           (pready)
);
`default_nettype wire

// File: sim/airspeed_from_pressure_samples_test.sv
// Self-checking testbench for airspeed_from_pressure_samples: ADC sample items
// in, pressure/velocity items out, checked against an in-bench predictor.
// Depends on asp_pkg and the block's RTL.
`timescale 1ns / 1ps
module airspeed_from_pressure_samples_test;
  import asp_pkg::*;

  typedef struct {
    logic [15:0] pressure;
    logic [15:0] velocity;
    logic        sat;
  } airspeed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = OP_CAL;
  logic [11:0] in_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_pressure_out;
  logic [15:0] out_velocity_out;
  logic        out_saturated;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  airspeed_from_pressure_samples dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [12:0] m_supply;
  logic [15:0] m_sens;
  logic [13:0] m_zofs;
  logic [14:0] m_temp;
  logic [16:0] m_amb;
  logic [21:0] m_sum;
  logic [10:0] m_count;
  logic        m_kind;
  logic [11:0] m_zero;

  airspeed_t airspeed_q[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  out_stall = 0;
  bit  in_idle = 1'b1;
  bit  out_idle = 1'b1;

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_airspeed(input logic op, input logic [11:0] smp);
    longint num;
    logic [63:0] den, p, pc, q, vel;
    longint tc;
    airspeed_t r;
    if (op != m_kind) begin
      m_kind = op;
      m_sum = 0;
      m_count = 0;
    end
    m_sum = m_sum + smp;
    m_count = m_count + 1;
    if (op == OP_CAL) begin
      if (m_count < CAL_SAMPLES) return;
      m_zero = 12'(m_sum / CAL_SAMPLES);
      m_sum = 0;
      m_count = 0;
      return;
    end
    if (m_count < AVG_SAMPLES) return;
    num = (longint'(m_sum) - longint'(m_zero) * AVG_SAMPLES) * 33000000
        - longint'(64'(m_zofs) * 64'(m_supply) * 4095 * AVG_SAMPLES);
    den = 64'(m_sens) * 64'(m_supply) * 4095 * AVG_SAMPLES;
    m_sum = 0;
    m_count = 0;
    p = (num <= 0 || den == 0) ? 64'd0 : (64'(num) * 10000) / den;
    r.sat = p > 65535;
    r.pressure = r.sat ? 16'hFFFF : p[15:0];
    if (p == 0) vel = 0;
    else if (m_amb == 0) begin
      vel = 65535;
      r.sat = 1'b1;
    end else begin
      pc = p > (64'd1 << 24) ? (64'd1 << 24) : p;
      tc = longint'($signed(m_temp)) + 27315;
      q = (pc * 5741 * 64'(tc)) / m_amb;
      if (q >= (64'd1 << 32)) begin
        vel = 65535;
        r.sat = 1'b1;
      end else vel = root64(q);
    end
    r.velocity = vel[15:0];
    airspeed_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n || out_idle) begin
      out_ready <= 1'b1;
      out_stall <= 0;
    end else if (out_stall != 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      out_stall <= int'($urandom_range(0, 3));
    end else begin
      out_ready <= 1'b1;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    airspeed_t e;
    if (rst_n && out_valid && out_ready) begin
      if (airspeed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item p=%0d v=%0d",
                                       out_pressure_out, out_velocity_out);
      end else begin
        e = airspeed_q.pop_front();
        if (e.pressure !== out_pressure_out || e.velocity !== out_velocity_out ||
            e.sat !== out_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp p=%0d v=%0d s=%0b got p=%0d v=%0d s=%0b",
                     e.pressure, e.velocity, e.sat, out_pressure_out,
                     out_velocity_out, out_saturated);
        end
      end
    end
  end

  task automatic send_sample(input logic op, input logic [11:0] smp);
    if (!in_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    predict_airspeed(op, smp);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (airspeed_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_SUPPLY: m_supply = val[12:0];
      REG_SENS:   m_sens = val[15:0];
      REG_ZOFS:   m_zofs = val[13:0];
      REG_TEMP:   m_temp = val[14:0];
      REG_AMB:    m_amb = val[16:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int s, input int k, input int o, input int t, input int a);
    drain();
    write_reg(REG_SUPPLY, s);
    write_reg(REG_SENS, k);
    write_reg(REG_ZOFS, o);
    write_reg(REG_TEMP, t);
    write_reg(REG_AMB, a);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_cal(input int base, input int spread);
    repeat (CAL_SAMPLES) send_sample(OP_CAL, 12'(base + $urandom_range(0, spread)));
  endtask

  task automatic run_meas(input int base, input int spread);
    repeat (AVG_SAMPLES) send_sample(OP_MEAS, 12'(base + $urandom_range(0, spread)));
  endtask

  task automatic test_directed;
    // measure before calibrate, then extremes
    repeat (AVG_SAMPLES) send_sample(OP_MEAS, 12'hFFF);
    repeat (3) send_sample(OP_CAL, 12'h000);
    repeat (AVG_SAMPLES) send_sample(OP_MEAS, 12'h000);
    // tag change mid-run
    repeat (5) send_sample(OP_MEAS, 12'hAAA);
    run_cal(0, 0);
    run_meas(4095, 0);
  endtask

  task automatic test_zero_divisor;
    set_regs(5000, 0, 5000, 2000, 101325);
    run_meas(3000, 500);
    set_regs(0, 2000, 0, 2000, 101325);
    run_meas(3000, 500);
  endtask

  task automatic test_zero_ambient;
    set_regs(5000, 2000, 0, 2000, 0);
    run_meas(3000, 500);
    run_meas(0, 0);
  endtask

  task automatic test_extremes;
    set_regs(1000, 1, 0, -4000, 30000);
    run_meas(2000, 2095);
    set_regs(5500, 65535, 10000, 8500, 110000);
    run_meas(2000, 2095);
    set_regs(8191, 65535, 16383, 16383, 131071);
    run_meas(0, 4095);
  endtask

  task automatic test_random;
    repeat (14) begin
      set_regs($urandom_range(1000, 5500), $urandom_range(1, 65535),
               $urandom_range(0, 10000), int'($urandom_range(0, 12500)) - 4000,
               $urandom_range(30000, 110000));
      if ($urandom_range(0, 2) == 0) run_cal($urandom_range(0, 2000), 2095);
      repeat (6) begin
        case ($urandom_range(0, 5))
          0: repeat ($urandom_range(1, 20))
               send_sample(1'($urandom), 12'($urandom));
          1: run_meas(0, 4095);
          default: run_meas($urandom_range(0, 3500), $urandom_range(0, 595));
        endcase
      end
    end
  endtask

  initial begin
    m_supply = SUPPLY_RST;
    m_sens = SENS_RST;
    m_zofs = ZOFS_RST;
    m_temp = TEMP_RST;
    m_amb = AMB_RST;
    m_sum = 0;
    m_count = 0;
    m_kind = OP_CAL;
    m_zero = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_idle = 1'b0;
    out_idle = 1'b0;
    test_directed();
    test_zero_divisor();
    test_zero_ambient();
    test_extremes();
    test_random();
    set_regs(5000, 2000, 5000, 2000, 101325);
    in_idle = 1'b1;
    out_idle = 1'b1;
    repeat (4) run_meas($urandom_range(0, 3500), 595);
    drain();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
